// ===== hdl/bldc_six_step_commutator_top_assert.svh =====
// Assertion macros shared by the checker of the commutator.
`ifndef BLDC_SIX_STEP_COMMUTATOR_TOP_ASSERT_SVH
`define BLDC_SIX_STEP_COMMUTATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BLDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("commutator assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BLDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("commutator assertion failed");

`endif

// ===== hdl/bldc_pkg.sv =====
package bldc_pkg;

   // Fixed field widths.
   localparam int TICK_BITS = 16;
   localparam int REV_BITS  = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STARTUP_REVS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_TICKS   = 2'd1;

   // Register reset values.
   localparam logic [REV_BITS-1:0]  STARTUP_REVS_RESET = 8'd100;
   localparam logic [TICK_BITS-1:0] STEP_TICKS_RESET   = 16'd200;

   // Phase in which sensorless running begins, and the number of phases.
   localparam logic [2:0] LAST_PHASE = 3'd5;
   localparam logic [2:0] NUM_PHASES = 3'd6;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RAMP  = 2'd1,
      MODE_WAIT  = 2'd2,
      MODE_DELAY = 2'd3
   } mode_type;

   typedef struct packed {
      logic start_req;
      logic above_u;
      logic above_v;
      logic above_w;
   } req_type;

   typedef struct packed {
      logic [5:0] gate_drive;
      logic [2:0] drive_phase;
      logic [1:0] run_mode;
      logic       crossing_seen;
      logic       commutated;
   } rsp_type;

   typedef struct packed {
      logic [REV_BITS-1:0]  startup_revs;
      logic [TICK_BITS-1:0] step_ticks;
   } cfg_type;

   // Gate pattern driven in each phase.
   function automatic logic [5:0] gate_pattern(input logic [2:0] phase);
      logic [5:0] pattern;
      begin
         case (phase)
            3'd0: pattern = 6'h0A;
            3'd1: pattern = 6'h0C;
            3'd2: pattern = 6'h14;
            3'd3: pattern = 6'h11;
            3'd4: pattern = 6'h21;
            3'd5: pattern = 6'h22;
            default: pattern = 6'h00;
         endcase
         return pattern;
      end
   endfunction

   // Comparator bit watched in each phase: 0 U, 1 V, 2 W.
   function automatic logic [1:0] watch_pole(input logic [2:0] phase);
      logic [1:0] pole;
      begin
         case (phase)
            3'd0, 3'd3: pole = 2'd2;
            3'd1, 3'd4: pole = 2'd1;
            default:    pole = 2'd0;
         endcase
         return pole;
      end
   endfunction

   // High when a rising edge is expected in that phase.
   function automatic logic watch_rise(input logic [2:0] phase);
      logic rise;
      begin
         case (phase)
            3'd1, 3'd3, 3'd5: rise = 1'b1;
            default:          rise = 1'b0;
         endcase
         return rise;
      end
   endfunction

endpackage

// ===== hdl/bldc_six_step_commutator_top.sv =====
// A tick accepted into the input register gives its result on rsp_valid from
// the result register (input register, then result register).
// Throughput: one tick per cycle unless rsp_stall holds the result register; the state update is a single pass of
// counter, compare and table logic between the two registers.
// Reset (synchronous, active high): idle mode, all switches off, counters
// cleared, startup_revs 100 and step_ticks 200.
module bldc_six_step_commutator_top #(
   parameter int TIMER_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bldc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bldc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [bldc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bldc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import bldc_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   cfg_type cfg_ff;
   logic    out_free, advance, req_take;

   // Flow control: the input register moves on when the result register is free.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   // Configuration registers; writes to other indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_revs <= STARTUP_REVS_RESET;
         cfg_ff.step_ticks   <= STEP_TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STARTUP_REVS: cfg_ff.startup_revs <= csr_wdata[REV_BITS-1:0];
            CSR_STEP_TICKS:   cfg_ff.step_ticks   <= csr_wdata[TICK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   bldc_ctrl #(
      .TIMER_BITS(TIMER_BITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step_en(advance),
      .req    (in_data_ff),
      .cfg    (cfg_ff),
      .rsp    (step_rsp)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hdl/bldc_ctrl.sv =====
module bldc_ctrl #(
   parameter int TIMER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  bldc_pkg::req_type req,
   input  bldc_pkg::cfg_type cfg,
   output bldc_pkg::rsp_type rsp
);
   import bldc_pkg::*;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   mode_type             mode_ff, mode_in;
   logic [2:0]           phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [REV_BITS-1:0]  rev_ff, rev_in;
   logic [2:0]           step_ff, step_in;
   logic [2:0]           prev_above_ff;
   logic [5:0]           drive_ff, drive_in;

   logic [2:0]           above;
   logic [2:0]           step_next;
   logic [REV_BITS-1:0]  rev_next;
   logic [1:0]           pole;
   logic                 was_high, now_high, edge_hit;
   logic                 crossing, commut;

   assign above     = {req.above_w, req.above_v, req.above_u};
   assign step_next = step_ff + 3'd1;
   assign rev_next  = rev_ff + {{(REV_BITS-1){1'b0}}, 1'b1};

   // Edge detection on the comparator bit that the current phase watches.
   assign pole     = watch_pole(phase_ff);
   assign was_high = prev_above_ff[pole];
   assign now_high = above[pole];
   assign edge_hit = watch_rise(phase_ff) ? (!was_high && now_high)
                                          : (was_high && !now_high);

   // Next state for one tick.
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      timer_in = timer_ff;
      tick_in  = tick_ff;
      rev_in   = rev_ff;
      step_in  = step_ff;
      drive_in = drive_ff;
      crossing = 1'b0;
      commut   = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (req.start_req) begin
               phase_in = 3'd0;
               step_in  = 3'd0;
               rev_in   = '0;
               tick_in  = {{(TICK_BITS-1){1'b0}}, 1'b1};
               if (cfg.startup_revs == '0) begin
                  mode_in  = MODE_WAIT;
                  phase_in = LAST_PHASE;
                  timer_in = '0;
               end else begin
                  mode_in  = MODE_RAMP;
                  drive_in = gate_pattern(3'd0);
               end
            end
         end
         MODE_RAMP: begin
            if (tick_ff >= cfg.step_ticks) begin
               tick_in = {{(TICK_BITS-1){1'b0}}, 1'b1};
               if (step_next >= NUM_PHASES) begin
                  step_in = 3'd0;
                  rev_in  = rev_next;
                  if (rev_next >= cfg.startup_revs) begin
                     mode_in  = MODE_WAIT;
                     phase_in = LAST_PHASE;
                     timer_in = '0;
                  end else begin
                     drive_in = gate_pattern(3'd0);
                  end
               end else begin
                  step_in  = step_next;
                  drive_in = gate_pattern(step_next);
               end
            end else begin
               tick_in = tick_ff + {{(TICK_BITS-1){1'b0}}, 1'b1};
            end
         end
         MODE_WAIT: begin
            if (edge_hit) begin
               crossing = 1'b1;
               mode_in  = MODE_DELAY;
            end else if (timer_ff != TIMER_MAX) begin
               timer_in = timer_ff + {{(TIMER_BITS-1){1'b0}}, 1'b1};
            end
         end
         MODE_DELAY: begin
            if (timer_ff == '0) begin
               phase_in = (phase_ff >= LAST_PHASE) ? 3'd0 : phase_ff + 3'd1;
               drive_in = gate_pattern(phase_in);
               mode_in  = MODE_WAIT;
               commut   = 1'b1;
            end else begin
               timer_in = timer_ff - {{(TIMER_BITS-1){1'b0}}, 1'b1};
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   // Result of the tick, built from the updated state.
   always_comb begin
      rsp.gate_drive    = drive_in;
      rsp.drive_phase   = phase_in;
      rsp.run_mode      = mode_in;
      rsp.crossing_seen = crossing;
      rsp.commutated    = commut;
   end

   // State registers, updated once per transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         phase_ff      <= '0;
         timer_ff      <= '0;
         tick_ff       <= '0;
         rev_ff        <= '0;
         step_ff       <= '0;
         prev_above_ff <= '0;
         drive_ff      <= '0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
         tick_ff       <= tick_in;
         rev_ff        <= rev_in;
         step_ff       <= step_in;
         prev_above_ff <= above;
         drive_ff      <= drive_in;
      end
   end

endmodule

// ===== hdl/bldc_chk.sv =====
module bldc_chk (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bldc_pkg::rsp_type rsp_data
);
   import bldc_pkg::*;

`include "bldc_six_step_commutator_top_assert.svh"

   // A stalled result holds.
   `BLDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A commutation always returns to awaiting the next crossing.
   `BLDC_ASSERT_IMPL(a_commut_wait, clock, reset, rsp_valid && rsp_data.commutated, rsp_data.run_mode == MODE_WAIT)

   // A crossing starts the countdown and never commutates on the same tick.
   `BLDC_ASSERT_IMPL(a_cross_delay, clock, reset, rsp_valid && rsp_data.crossing_seen, (rsp_data.run_mode == MODE_DELAY) && !rsp_data.commutated)

   // While idle, nothing is switched on.
   `BLDC_ASSERT_IMPL(a_idle_off, clock, reset, rsp_valid && (rsp_data.run_mode == MODE_IDLE), (rsp_data.gate_drive == 6'h00) && (rsp_data.drive_phase == 3'd0))

endmodule

bind bldc_six_step_commutator_top bldc_chk u_bldc_chk (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
